// ===== sv/pyalu_pkg.sv =====
`timescale 1ns / 1ps

package pyalu_pkg;

  localparam int WORD_BITS_DEFAULT = 64;

  typedef enum logic [3:0] {
    K_ADD      = 4'd0,
    K_SUB      = 4'd1,
    K_MUL      = 4'd2,
    K_FLOORDIV = 4'd3,
    K_MOD      = 4'd4,
    K_SHL      = 4'd5,
    K_SHR      = 4'd6,
    K_AND      = 4'd7,
    K_OR       = 4'd8,
    K_XOR      = 4'd9,
    K_EQ       = 4'd10,
    K_NE       = 4'd11,
    K_LT       = 4'd12,
    K_LE       = 4'd13,
    K_GT       = 4'd14,
    K_GE       = 4'd15
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic signed [63:0] lhs_value;
    logic signed [63:0] rhs_value;
    logic               lhs_valid;
    logic               rhs_valid;
  } op_t;

  typedef struct packed {
    logic signed [63:0] result;
    logic               refused;
    logic               result_valid;
  } res_t;

endpackage

// ===== sv/python_int64_alu_with_fallback_flag.sv =====
`timescale 1ns / 1ps

// Channel | Signals                      | Transaction
// op      | op_valid, op_ready, op       | opcode, two operands, operand valid bits
// res     | res_valid, res_ready, res    | wrapped result, refused, result_valid
//
// A transaction passes through every stage before its result is offered;
// one transaction enters per cycle while the first stage is free (op_ready).
// The depth is set by the divider, which resolves one quotient bit per stage.
// Every stage has its own valid bit and advances when its successor is free,
// so bubbles close up and a stalled output holds only the stages behind it.
// Synchronous reset clears all valid bits; data registers are not reset.

module python_int64_alu_with_fallback_flag #(
  parameter int WORD_BITS = pyalu_pkg::WORD_BITS_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             op_valid,
  output logic             op_ready,
  input  pyalu_pkg::op_t   op,
  output logic             res_valid,
  input  logic             res_ready,
  output pyalu_pkg::res_t  res
);

  localparam int W  = WORD_BITS;
  localparam int L  = (W + 1) / 2;
  localparam int H  = W - L;
  localparam int PW = 2 * W;
  localparam int CW = $clog2(W);

  localparam int S_FAST = 1;
  localparam int S_PP   = 2;
  localparam int S_MID  = 3;
  localparam int S_PROD = 4;
  localparam int S_MUL  = 5;
  localparam int S_DIV0 = 6;
  localparam int S_SIGN = S_DIV0 + W;
  localparam int S_FIX  = S_SIGN + 1;
  localparam int NS     = S_FIX + 1;

  localparam logic [W-1:0] WMIN = W'(1) << (W - 1);

  typedef struct packed {
    pyalu_pkg::kind_t kind;
    logic             vin;
    logic [W-1:0]     a;
    logic [W-1:0]     b;
    logic [W-1:0]     r;
    logic             refused;
    logic             neg_a;
    logic             neg_b;
    logic [W-1:0]     ua;
    logic [W-1:0]     ub;
    logic [2*L-1:0]   ll;
    logic [W-1:0]     lh;
    logic [W-1:0]     hl;
    logic [2*H-1:0]   hh;
    logic [W:0]       mid;
    logic [PW-1:0]    prod;
    logic [W-1:0]     rem;
    logic [W-1:0]     quo;
  } stage_t;

  stage_t      pipe      [NS];
  stage_t      pipe_next [NS];
  logic [NS-1:0] vld;
  logic [NS-1:0] adv;

  function automatic stage_t f_load(input pyalu_pkg::op_t i);
    stage_t o;
    o = '0;
    o.kind = i.kind;
    o.vin  = i.lhs_valid & i.rhs_valid;
    o.a    = i.lhs_value[W-1:0];
    o.b    = i.rhs_value[W-1:0];
    return o;
  endfunction

  function automatic stage_t f_fast(input stage_t s);
    stage_t         o;
    logic [W-1:0]   sum;
    logic [W-1:0]   dif;
    logic [W-1:0]   bb;
    logic           ref_div;
    logic           oor;
    logic [CW-1:0]  c;
    o       = s;
    sum     = s.a + s.b;
    dif     = s.a - s.b;
    ref_div = (s.b == '0) || ((s.a == WMIN) && (s.b == '1));
    bb      = ((s.kind == pyalu_pkg::K_FLOORDIV || s.kind == pyalu_pkg::K_MOD) && ref_div)
              ? W'(1) : s.b;
    oor     = s.b[W-1] || (s.b >= W'(W));
    o.b       = bb;
    o.neg_a   = s.a[W-1];
    o.neg_b   = bb[W-1];
    o.ua      = s.a[W-1] ? -s.a : s.a;
    o.ub      = bb[W-1] ? -bb : bb;
    o.rem     = '0;
    o.quo     = '0;
    o.r       = '0;
    o.refused = 1'b0;
    c         = '0;
    unique case (s.kind)
      pyalu_pkg::K_ADD: begin
        o.r       = sum;
        o.refused = (s.a[W-1] == s.b[W-1]) && (sum[W-1] != s.a[W-1]);
      end
      pyalu_pkg::K_SUB: begin
        o.r       = dif;
        o.refused = (s.a[W-1] != s.b[W-1]) && (dif[W-1] != s.a[W-1]);
      end
      pyalu_pkg::K_MUL: begin
        o.refused = 1'b0;
      end
      pyalu_pkg::K_FLOORDIV, pyalu_pkg::K_MOD: begin
        o.refused = ref_div;
      end
      pyalu_pkg::K_SHL: begin
        c         = oor ? '0 : s.b[CW-1:0];
        o.r       = s.a << c;
        o.refused = oor || (W'($signed(o.r) >>> c) != s.a);
      end
      pyalu_pkg::K_SHR: begin
        if (s.b[W-1]) begin
          c = '0;
        end else if (s.b > W'(W - 1)) begin
          c = CW'(W - 1);
        end else begin
          c = s.b[CW-1:0];
        end
        o.r       = W'($signed(s.a) >>> c);
        o.refused = s.b[W-1];
      end
      pyalu_pkg::K_AND: o.r = s.a & s.b;
      pyalu_pkg::K_OR:  o.r = s.a | s.b;
      pyalu_pkg::K_XOR: o.r = s.a ^ s.b;
      pyalu_pkg::K_EQ:  o.r = W'(s.a == s.b);
      pyalu_pkg::K_NE:  o.r = W'(s.a != s.b);
      pyalu_pkg::K_LT:  o.r = W'($signed(s.a) < $signed(s.b));
      pyalu_pkg::K_LE:  o.r = W'($signed(s.a) <= $signed(s.b));
      pyalu_pkg::K_GT:  o.r = W'($signed(s.a) > $signed(s.b));
      pyalu_pkg::K_GE:  o.r = W'($signed(s.a) >= $signed(s.b));
    endcase
    return o;
  endfunction

  function automatic stage_t f_pp(input stage_t s);
    stage_t o;
    o    = s;
    o.ll = s.ua[L-1:0] * s.ub[L-1:0];
    o.lh = s.ua[L-1:0] * s.ub[W-1:L];
    o.hl = s.ua[W-1:L] * s.ub[L-1:0];
    o.hh = s.ua[W-1:L] * s.ub[W-1:L];
    return o;
  endfunction

  function automatic stage_t f_mid(input stage_t s);
    stage_t o;
    o     = s;
    o.mid = {1'b0, s.lh} + {1'b0, s.hl};
    return o;
  endfunction

  function automatic stage_t f_prod(input stage_t s);
    stage_t o;
    o      = s;
    o.prod = PW'(s.ll) + (PW'(s.mid) << L) + (PW'(s.hh) << (2 * L));
    return o;
  endfunction

  function automatic stage_t f_mul(input stage_t s);
    stage_t       o;
    logic [W-1:0] lo;
    logic         neg;
    o   = s;
    lo  = s.prod[W-1:0];
    neg = s.neg_a ^ s.neg_b;
    if (s.kind == pyalu_pkg::K_MUL) begin
      o.r       = neg ? -lo : lo;
      o.refused = (|s.prod[PW-1:W]) || (neg ? (lo > WMIN) : (lo >= WMIN));
    end
    return o;
  endfunction

  function automatic stage_t f_div(input stage_t s);
    stage_t     o;
    logic [W:0] rem2;
    logic [W:0] diff;
    o    = s;
    rem2 = {s.rem, s.ua[W-1]};
    diff = rem2 - {1'b0, s.ub};
    o.ua = s.ua << 1;
    if (!diff[W]) begin
      o.rem = diff[W-1:0];
      o.quo = {s.quo[W-2:0], 1'b1};
    end else begin
      o.rem = rem2[W-1:0];
      o.quo = {s.quo[W-2:0], 1'b0};
    end
    return o;
  endfunction

  function automatic stage_t f_sign(input stage_t s);
    stage_t o;
    o     = s;
    o.quo = (s.neg_a ^ s.neg_b) ? -s.quo : s.quo;
    o.rem = s.neg_a ? -s.rem : s.rem;
    return o;
  endfunction

  function automatic stage_t f_fix(input stage_t s);
    stage_t o;
    logic   adj;
    o   = s;
    adj = (s.rem != '0) && (s.rem[W-1] != s.neg_b);
    if (s.kind == pyalu_pkg::K_FLOORDIV) begin
      o.r = adj ? s.quo - W'(1) : s.quo;
    end else if (s.kind == pyalu_pkg::K_MOD) begin
      o.r = adj ? s.rem + s.b : s.rem;
    end
    return o;
  endfunction

  always_comb begin
    adv[NS-1] = !vld[NS-1] || res_ready;
    for (int s = NS - 2; s >= 0; s--) begin
      adv[s] = !vld[s] || adv[s+1];
    end
  end

  always_comb begin
    pipe_next[0] = f_load(op);
    for (int s = 1; s < NS; s++) begin
      if (s == S_FAST) begin
        pipe_next[s] = f_fast(pipe[s-1]);
      end else if (s == S_PP) begin
        pipe_next[s] = f_pp(pipe[s-1]);
      end else if (s == S_MID) begin
        pipe_next[s] = f_mid(pipe[s-1]);
      end else if (s == S_PROD) begin
        pipe_next[s] = f_prod(pipe[s-1]);
      end else if (s == S_MUL) begin
        pipe_next[s] = f_mul(pipe[s-1]);
      end else if (s < S_SIGN) begin
        pipe_next[s] = f_div(pipe[s-1]);
      end else if (s == S_SIGN) begin
        pipe_next[s] = f_sign(pipe[s-1]);
      end else begin
        pipe_next[s] = f_fix(pipe[s-1]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= (vld & ~adv) | (adv & {vld[NS-2:0], op_valid});
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < NS; s++) begin
      if (adv[s]) begin
        pipe[s] <= pipe_next[s];
      end
    end
  end

  assign op_ready         = adv[0];
  assign res_valid        = vld[NS-1];
  assign res.result       = 64'($signed(pipe[NS-1].r));
  assign res.refused      = pipe[NS-1].refused;
  assign res.result_valid = pipe[NS-1].vin & ~pipe[NS-1].refused;

`ifndef SYNTHESIS
  a_full_only_when_stalled: assert property (@(posedge clk) disable iff (rst)
    !op_ready |-> (res_valid && !res_ready))
    else $error("input blocked while output is free");

  a_accept_loads: assert property (@(posedge clk) disable iff (rst)
    (op_valid && op_ready) |=> vld[0])
    else $error("accepted transaction not held in first stage");

  a_cmp_bool: assert property (@(posedge clk) disable iff (rst)
    (res_valid && pipe[NS-1].kind >= pyalu_pkg::K_EQ) |-> (pipe[NS-1].r[W-1:1] == '0))
    else $error("comparison result is not 0 or 1");

  a_logic_never_refused: assert property (@(posedge clk) disable iff (rst)
    (res_valid && pipe[NS-1].kind >= pyalu_pkg::K_AND) |-> !res.refused)
    else $error("bitwise or comparison transaction refused");
`endif

endmodule
